// ----- src/kfh_pkg.sv -----
// Shared constants and types for the k-mer frequency histogram.
// No dependencies; used by every module of the block.
package kfh_pkg;

	localparam int MAX_K       = 6;
	localparam int COUNT_WIDTH = 16;

	localparam int BIN_W     = 2 * MAX_K;
	localparam int BIN_TOTAL = 1 << BIN_W;
	localparam int SEEN_W    = $clog2(MAX_K + 1);
	localparam int K_W       = 3;
	localparam int IDX_W     = 12;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// operation codes carried on tuser
	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_NEW_SEQ = 2'd2;

	// window unit result for the base now being pushed
	typedef struct packed {
		logic             hit;
		logic [BIN_W-1:0] bin;
	} win_t;

endpackage

// ----- src/kfh_window.sv -----
// Base window and k-mer bin address for the k-mer frequency histogram.
// Depends on kfh_pkg.
module kfh_window (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic                      new_seq,
	input  logic [1:0]                base,
	input  logic [kfh_pkg::K_W-1:0]   kmer_length,
	output kfh_pkg::win_t             win
);

	logic [kfh_pkg::BIN_W-1:0]  window_q;
	logic [kfh_pkg::SEEN_W-1:0] seen_q;
	logic [kfh_pkg::BIN_W-1:0]  window_next;
	logic [kfh_pkg::SEEN_W-1:0] seen_next;
	logic [kfh_pkg::SEEN_W-1:0] k_eff;
	logic [kfh_pkg::BIN_W-1:0]  mask;

	// clamp k into 1..MAX_K
	always_comb begin
		if (kmer_length == '0) begin
			k_eff = kfh_pkg::SEEN_W'(1);
		end else if (32'(kmer_length) > kfh_pkg::MAX_K) begin
			k_eff = kfh_pkg::SEEN_W'(kfh_pkg::MAX_K);
		end else begin
			k_eff = kfh_pkg::SEEN_W'(kmer_length);
		end
	end

	always_comb begin
		for (int d = 0; d < kfh_pkg::MAX_K; d++) begin
			mask[2*d +: 2] = (kfh_pkg::SEEN_W'(d) < k_eff) ? 2'b11 : 2'b00;
		end
	end

	assign window_next = kfh_pkg::BIN_W'({window_q, base});
	assign seen_next   = (32'(seen_q) == kfh_pkg::MAX_K) ? seen_q
	                                                    : seen_q + kfh_pkg::SEEN_W'(1);

	assign win.hit = (seen_next >= k_eff);
	assign win.bin = window_next & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
		end else if (new_seq) begin
			window_q <= '0;
			seen_q   <= '0;
		end else if (push) begin
			window_q <= window_next;
			seen_q   <= seen_next;
		end
	end

endmodule

// ----- src/kmer_frequency_histogram.sv -----
// k-mer frequency histogram: top level with the count memory and its
// read-modify-write pipeline. Depends on kfh_pkg and kfh_window.
// Throughput: one word per cycle; s_tready drops while a read result waits behind
// a stalled output word. Memory read on accept, written back by the write-back stage.
// A read's bin_count reaches m_tdata through the write-back stage and output register.
// Reset: asynchronous; then a clearing pass zeroes memory, s_tready low.
module kmer_frequency_histogram (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: kmer_length
	input  logic                            cfg_we,
	input  logic [kfh_pkg::K_W-1:0]         cfg_data,
	// input words
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // [1:0] base_code, [13:2] bin_index
	input  logic [1:0]                      s_tuser,   // [1:0] operation
	// result words
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [kfh_pkg::COUNT_WIDTH-1:0] m_tdata    // [15:0] bin_count
);

	// count memory, no reset: the clearing pass takes care of it
	logic [kfh_pkg::COUNT_WIDTH-1:0] mem [kfh_pkg::BIN_TOTAL];
	logic [kfh_pkg::COUNT_WIDTH-1:0] rdata_q;

	logic                      clr_q;
	logic [kfh_pkg::BIN_W-1:0] clr_addr_q;
	logic [kfh_pkg::K_W-1:0]   k_q;

	// write-back stage
	logic                            valid_s1;
	logic                            read_s1;
	logic [kfh_pkg::BIN_W-1:0]       addr_s1;
	logic                            fwd_s1;
	logic [kfh_pkg::COUNT_WIDTH-1:0] fwd_data_s1;

	logic                            out_valid_q;
	logic [kfh_pkg::COUNT_WIDTH-1:0] out_data_q;

	logic [1:0]                      op;
	logic [1:0]                      base;
	logic [kfh_pkg::IDX_W-1:0]       bin_index;
	logic                            acc, acc_push, acc_read, acc_new;
	logic                            needs_wr;
	logic [kfh_pkg::BIN_W-1:0]       acc_addr;
	logic                            stall_s1, done_s1;
	logic [kfh_pkg::COUNT_WIDTH-1:0] old_val, new_val;
	kfh_pkg::win_t                   win;

	assign op        = s_tuser;
	assign base      = s_tdata[1:0];
	assign bin_index = s_tdata[13:2];

	// a read result cannot leave while the output register is still full
	assign stall_s1 = valid_s1 && read_s1 && out_valid_q && !m_tready;
	assign done_s1  = valid_s1 && !stall_s1;

	assign s_tready = !clr_q && !stall_s1;
	assign acc      = s_tvalid && s_tready;
	assign acc_push = acc && (op == kfh_pkg::OP_PUSH);
	assign acc_read = acc && (op == kfh_pkg::OP_READ);
	assign acc_new  = acc && (op == kfh_pkg::OP_NEW_SEQ);

	kfh_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (acc_push),
		.new_seq     (acc_new),
		.base        (base),
		.kmer_length (k_q),
		.win         (win)
	);

	// only counted pushes and reads write the memory; other words just pass
	assign needs_wr = (acc_push && win.hit) || acc_read;
	assign acc_addr = acc_read ? kfh_pkg::BIN_W'(bin_index) : win.bin;

	// take the value the previous word wrote when it hit the same bin
	assign old_val = fwd_s1 ? fwd_data_s1 : rdata_q;

	always_comb begin
		if (read_s1) begin
			new_val = '0;
		end else if (old_val == kfh_pkg::COUNT_MAX) begin
			new_val = old_val;
		end else begin
			new_val = old_val + kfh_pkg::COUNT_WIDTH'(1);
		end
	end

	// memory port: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (done_s1) begin
			mem[addr_s1] <= new_val;
		end
		if (acc) begin
			rdata_q <= mem[acc_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			k_q         <= kfh_pkg::K_W'(2);
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				k_q <= cfg_data;
			end
			// sweep the memory once after reset
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + kfh_pkg::BIN_W'(1);
				if (32'(clr_addr_q) == kfh_pkg::BIN_TOTAL - 1) begin
					clr_q <= 1'b0;
				end
			end
			// advance the write-back stage; hold it while stalled
			if (acc) begin
				valid_s1 <= needs_wr;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
			end
			// load the output register or drop a taken word
			if (done_s1 && read_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			read_s1     <= acc_read;
			addr_s1     <= acc_addr;
			fwd_s1      <= done_s1 && (addr_s1 == acc_addr);
			fwd_data_s1 <= new_val;
		end
		if (done_s1 && read_s1) begin
			out_data_q <= old_val;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- src/kfh_checker.sv -----
// Port-level checks for the k-mer frequency histogram, bound to the top.
// Depends on kfh_pkg and kmer_frequency_histogram.
module kfh_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [1:0]                      s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [kfh_pkg::COUNT_WIDTH-1:0] m_tdata
);

	logic acc_read;
	assign acc_read = s_tvalid && s_tready && (s_tuser == kfh_pkg::OP_READ);

	// clearing pass keeps the input closed right after reset
	a_clear_closed: assert property (@(posedge clk) $rose(arst_n) |-> !s_tready)
		else $error("input open during clearing pass");

	// a new result only ever follows an accepted read, via the write-back stage and output register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(acc_read, 2))
		else $error("result without a read");

	// every read is followed by a valid result once through the write-back stage and output register
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc_read |-> ##2 m_tvalid)
		else $error("read produced no result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind kmer_frequency_histogram kfh_checker u_kfh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- verif/tb.sv -----
// Self-checking testbench for kmer_frequency_histogram: stream driver, result monitor
// and a count predictor. Depends on kfh_pkg and the block's top level.
// Covers directed k-mer cases and random traffic under several idle mixes.
module tb;

	// operation code the block must ignore
	localparam logic [1:0] OP_IGNORED = 2'd3;
	// generous cycle budget: clearing pass and random phases with stalls
	localparam int CYCLE_LIMIT = 60000;
	localparam int RANDOM_PHASES = 12;
	localparam int WORDS_PER_PHASE = 96;

	// idle mixes: none, sender idle, receiver stall, both lightly
	typedef enum int {MIX_NONE, MIX_SEND_IDLE, MIX_RECV_STALL, MIX_BOTH} idle_mix_t;

	typedef struct packed {
		logic [1:0]                op;
		logic [1:0]                base;
		logic [kfh_pkg::IDX_W-1:0] bin;
	} kmer_word_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [kfh_pkg::K_W-1:0]         cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [15:0]                     s_tdata = '0;   // [1:0] base_code, [13:2] bin_index, [15:14] zero
	logic [1:0]                      s_tuser = '0;   // [1:0] operation
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [kfh_pkg::COUNT_WIDTH-1:0] m_tdata;        // [15:0] bin_count

	kmer_frequency_histogram dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state: histogram, base window, bases seen, programmed k
	logic [kfh_pkg::COUNT_WIDTH-1:0] hist_bins [kfh_pkg::BIN_TOTAL];
	logic [kfh_pkg::BIN_W-1:0]       win_bases;
	logic [kfh_pkg::SEEN_W-1:0]      seen_cnt;
	logic [kfh_pkg::K_W-1:0]         k_reg;

	kmer_word_t                      pending_words[$];
	logic [kfh_pkg::COUNT_WIDTH-1:0] due_counts[$];
	idle_mix_t                       idle_mix = MIX_NONE;

	int err_cnt = 0;
	int push_cnt = 0;
	int read_cnt = 0;
	int newseq_cnt = 0;
	int ignored_cnt = 0;
	int cycle_cnt = 0;
	logic [7:0] k_written = '0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @cycle %0d: %s", cycle_cnt, msg);
		err_cnt++;
	endtask

	// Clamp the programmed k to the range the block supports.
	function automatic int clamp_k(input logic [kfh_pkg::K_W-1:0] k);
		if (k < 1)
			return 1;
		if (k > kfh_pkg::MAX_K)
			return kfh_pkg::MAX_K;
		return int'(k);
	endfunction

	// Apply one accepted word to the predicted histogram; queue the count a read returns.
	task automatic track_word(input kmer_word_t w);
		int                        k;
		logic [kfh_pkg::BIN_W-1:0] sel;
		case (w.op)
			kfh_pkg::OP_PUSH: begin
				push_cnt++;
				k = clamp_k(k_reg);
				win_bases = {win_bases[kfh_pkg::BIN_W-3:0], w.base};
				if (seen_cnt < kfh_pkg::MAX_K)
					seen_cnt++;
				if (seen_cnt >= k) begin
					sel = win_bases & kfh_pkg::BIN_W'((1 << (2 * k)) - 1);
					if (hist_bins[sel] != kfh_pkg::COUNT_MAX)
						hist_bins[sel]++;
				end
			end
			kfh_pkg::OP_READ: begin
				read_cnt++;
				due_counts.push_back(hist_bins[w.bin]);
				hist_bins[w.bin] = '0;
			end
			kfh_pkg::OP_NEW_SEQ: begin
				newseq_cnt++;
				win_bases = '0;
				seen_cnt = '0;
			end
			default: ignored_cnt++;
		endcase
	endtask

	// Driver: hold a word until accepted, then present the next or idle per the mix.
	always @(posedge clk or negedge arst_n) begin
		kmer_word_t nxt;
		logic       accepted;
		logic       idle_now;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			accepted = s_tvalid && s_tready;
			if (accepted)
				track_word('{op: s_tuser, base: s_tdata[1:0], bin: s_tdata[13:2]});
			if (!s_tvalid || accepted) begin
				case (idle_mix)
					MIX_SEND_IDLE: idle_now = ($urandom_range(99) < 62);
					MIX_BOTH:      idle_now = ($urandom_range(99) < 20);
					default:       idle_now = 1'b0;
				endcase
				if (pending_words.size() != 0 && !idle_now) begin
					nxt = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nxt.op;
					s_tdata <= {2'b00, nxt.bin, nxt.base};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest due count; stall per the mix.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_counts.size() == 0) begin
					report_mismatch($sformatf("bin_count %0d with no read outstanding",
						m_tdata));
				end else begin
					if (m_tdata !== due_counts[0])
						report_mismatch($sformatf("bin_count got %0d, want %0d",
							m_tdata, due_counts[0]));
					void'(due_counts.pop_front());
				end
			end
			case (idle_mix)
				MIX_RECV_STALL: m_tready <= ($urandom_range(99) >= 62);
				MIX_BOTH:       m_tready <= ($urandom_range(99) >= 20);
				default:        m_tready <= 1'b1;
			endcase
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d reads still due", cycle_cnt,
				due_counts.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic add_word(input logic [1:0] op, input logic [1:0] base,
		input logic [kfh_pkg::IDX_W-1:0] bin);
		pending_words.push_back('{op: op, base: base, bin: bin});
	endtask

	// Wait until every word is accepted and every read has returned, then let the
	// pipeline settle, since pushes leave no result to wait on.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || s_tvalid || due_counts.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	// Program k while idle; the predictor follows at once.
	task automatic write_k(input logic [kfh_pkg::K_W-1:0] k);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		k_reg = k;
		k_written[k] = 1'b1;
	endtask

	// One random phase: mostly push bursts with reads aimed at recent k-mers,
	// plus random reads, new sequences and ignored words as noise.
	task automatic random_phase(input int target);
		int                        sent;
		int                        burst;
		int                        k;
		logic [kfh_pkg::BIN_W-1:0] gen_win;
		logic [1:0]                b;
		int                        r;
		sent = 0;
		gen_win = '0;
		k = clamp_k(k_reg);
		while (sent < target) begin
			r = $urandom_range(99);
			if (r < 60) begin
				burst = $urandom_range(12, 1);
				repeat (burst) begin
					b = 2'($urandom);
					gen_win = {gen_win[kfh_pkg::BIN_W-3:0], b};
					add_word(kfh_pkg::OP_PUSH, b, kfh_pkg::IDX_W'($urandom));
				end
				sent += burst;
			end else if (r < 85) begin
				if ($urandom_range(1))
					add_word(kfh_pkg::OP_READ, 2'($urandom),
						kfh_pkg::IDX_W'(gen_win & kfh_pkg::BIN_W'((1 << (2 * k)) - 1)));
				else
					add_word(kfh_pkg::OP_READ, 2'($urandom), kfh_pkg::IDX_W'($urandom));
				sent++;
			end else if (r < 95) begin
				gen_win = '0;
				add_word(kfh_pkg::OP_NEW_SEQ, 2'($urandom), kfh_pkg::IDX_W'($urandom));
				sent++;
			end else begin
				add_word(OP_IGNORED, 2'($urandom), kfh_pkg::IDX_W'($urandom));
			end
		end
	endtask

	initial begin
		logic [kfh_pkg::K_W-1:0] k_plan [RANDOM_PHASES];
		k_plan = '{3'd1, 3'd6, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0, 3'd7, 3'd6, 3'd1, 3'd3, 3'd2};
		foreach (hist_bins[i])
			hist_bins[i] = '0;
		win_bases = '0;
		seen_cnt = '0;
		k_reg = 3'd2;

		// Hold reset, then release; the driver waits out the clearing pass on s_tready.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset k of 2.
		add_word(kfh_pkg::OP_PUSH, 2'd0, '0);
		add_word(kfh_pkg::OP_PUSH, 2'd1, '0);
		add_word(kfh_pkg::OP_PUSH, 2'd2, '0);
		add_word(kfh_pkg::OP_PUSH, 2'd3, '1);
		add_word(kfh_pkg::OP_READ, 2'd0, 12'd1);
		add_word(kfh_pkg::OP_READ, 2'd3, 12'd6);
		add_word(kfh_pkg::OP_READ, 2'd0, 12'd11);
		// bin outside 4^k, and an ignored operation with all bits set
		add_word(kfh_pkg::OP_READ, 2'd3, 12'hFFF);
		add_word(OP_IGNORED, 2'd3, 12'hFFF);
		add_word(kfh_pkg::OP_NEW_SEQ, 2'd0, '0);
		add_word(kfh_pkg::OP_PUSH, 2'd3, '0);
		add_word(kfh_pkg::OP_PUSH, 2'd3, '0);
		add_word(kfh_pkg::OP_READ, 2'd0, 12'd15);
		add_word(kfh_pkg::OP_NEW_SEQ, 2'd3, 12'hFFF);
		add_word(kfh_pkg::OP_PUSH, 2'd2, '0);
		add_word(kfh_pkg::OP_PUSH, 2'd1, '0);
		wait_drained();

		// Change k mid-sequence: the window keeps G,C and the next push counts GCA.
		write_k(3'd3);
		add_word(kfh_pkg::OP_PUSH, 2'd0, '0);
		add_word(kfh_pkg::OP_READ, 2'd0, 12'd36);
		add_word(kfh_pkg::OP_READ, 2'd0, 12'd9);
		wait_drained();

		// k above the maximum acts as the maximum: six T's fill the top bin.
		write_k(3'd7);
		add_word(kfh_pkg::OP_NEW_SEQ, 2'd0, '0);
		repeat (kfh_pkg::MAX_K) add_word(kfh_pkg::OP_PUSH, 2'd3, '0);
		add_word(kfh_pkg::OP_READ, 2'd0, 12'hFFF);
		wait_drained();

		// k of zero acts as one.
		write_k(3'd0);
		add_word(kfh_pkg::OP_PUSH, 2'd0, '0);
		add_word(kfh_pkg::OP_PUSH, 2'd0, '0);
		add_word(kfh_pkg::OP_READ, 2'd0, 12'd0);
		wait_drained();

		// Random phases: rotate the idle mix and step k through every setting.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_k(k_plan[p]);
			idle_mix = idle_mix_t'(p % 4);
			random_phase(WORDS_PER_PHASE);
			wait_drained();
			idle_mix = MIX_NONE;
		end

		repeat (8) @(negedge clk);
		$display("Ran %0d pushes, %0d reads, %0d new sequences, %0d ignored words",
			push_cnt, read_cnt, newseq_cnt, ignored_cnt);
		$display("k settings written mask %b, across four idle mixes", k_written);
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/kfh_pkg.sv
src/kfh_window.sv
src/kmer_frequency_histogram.sv
src/kfh_checker.sv
verif/tb.sv
